// ===== hw/rtl/gcb_pkg.sv =====
// shared types, register codes and the divide-by-255 helper of the glyph blender
package gcb_pkg;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 4;

	typedef enum logic [2:0] {
		REG_FG_COLOR    = 3'd0,
		REG_X_OFFSET    = 3'd1,
		REG_Y_OFFSET    = 3'd2,
		REG_GLYPH_COLS  = 3'd3,
		REG_GLYPH_ROWS  = 3'd4,
		REG_CLIP_WIDTH  = 3'd5,
		REG_CLIP_HEIGHT = 3'd6,
		REG_LINE_SIZE   = 3'd7
	} cfg_reg_e;

	typedef struct packed {
		logic [31:0]        fg_color;
		logic signed [12:0] x_offset;
		logic signed [12:0] y_offset;
		logic [8:0]         glyph_cols;
		logic [8:0]         glyph_rows;
		logic [12:0]        clip_width;
		logic [12:0]        clip_height;
		logic [12:0]        line_size;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  coverage;
		logic [31:0] dest_pixel;
	} in_item_t;

	typedef struct packed {
		logic        write_enable;
		logic [23:0] pixel_index;
		logic [31:0] blended_pixel;
		logic        glyph_done;
	} out_item_t;

	// classified pixel handed from the front to the back
	typedef struct packed {
		logic [7:0]  coverage;
		logic [31:0] dest_pixel;
		logic        visible;
		logic [12:0] col;
		logic [12:0] row;
		logic        done;
	} task_t;

	// exact x/255 for x up to 255*255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'(x[15:8]) + 17'd1;
		return t[15:8];
	endfunction

endpackage

// ===== hw/rtl/gcb_fifo.sv =====
// small register queue used between the stages and at the result side
module gcb_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [W-1:0]               wr_data,
	output logic                       full,
	input  logic                       rd_en,
	output logic [W-1:0]               rd_data,
	output logic                       empty,
	output logic [$clog2(DEPTH):0]     count
);

	localparam int AW = $clog2(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= AW'(wr_ptr_q + 1'b1);
			end
			if (do_rd) begin
				rd_ptr_q <= AW'(rd_ptr_q + 1'b1);
			end
			if (do_wr && !do_rd) begin
				count_q <= (AW+1)'(count_q + 1'b1);
			end else if (do_rd && !do_wr) begin
				count_q <= (AW+1)'(count_q - 1'b1);
			end
		end
	end

endmodule

// ===== hw/rtl/gcb_front.sv =====
// raster position counters, clip test and glyph-end detection
module gcb_front #(
	parameter int MAX_GLYPH_SIZE   = 256,
	parameter int MAX_SURFACE_SIZE = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gcb_pkg::cfg_t     cfg,
	input  logic              push,
	input  gcb_pkg::in_item_t item,
	input  logic              q_full,
	output logic              q_wr,
	output gcb_pkg::task_t    q_data
);

	localparam int CW = $clog2(MAX_GLYPH_SIZE);
	localparam int LW = ((CW + 1 > 9) ? CW + 1 : 9) + 1;
	localparam int PW = ((CW > 12) ? CW : 12) + 2;
	localparam logic [LW-1:0] GMAX = LW'(MAX_GLYPH_SIZE);
	localparam logic [PW-1:0] SMAX = PW'(MAX_SURFACE_SIZE);

	logic [CW-1:0]        col_q;
	logic [CW-1:0]        row_q;
	logic [LW-1:0]        cols_eff;
	logic [LW-1:0]        rows_eff;
	logic [LW-1:0]        cols_raw;
	logic [LW-1:0]        rows_raw;
	logic [PW-1:0]        clipw_raw;
	logic [PW-1:0]        cliph_raw;
	logic [PW-1:0]        clipw;
	logic [PW-1:0]        cliph;
	logic signed [PW-1:0] sx;
	logic signed [PW-1:0] sy;
	logic                 last_col;
	logic                 last_row;
	logic                 visible;

	always_comb begin
		cols_raw  = LW'(cfg.glyph_cols);
		rows_raw  = LW'(cfg.glyph_rows);
		// zero size acts as one, oversize clamps
		cols_eff  = (cols_raw == '0) ? LW'(1) : ((cols_raw > GMAX) ? GMAX : cols_raw);
		rows_eff  = (rows_raw == '0) ? LW'(1) : ((rows_raw > GMAX) ? GMAX : rows_raw);
		last_col  = (LW'(col_q) + LW'(1)) >= cols_eff;
		last_row  = (LW'(row_q) + LW'(1)) >= rows_eff;
		clipw_raw = PW'(cfg.clip_width);
		cliph_raw = PW'(cfg.clip_height);
		clipw     = (clipw_raw > SMAX) ? SMAX : clipw_raw;
		cliph     = (cliph_raw > SMAX) ? SMAX : cliph_raw;
		sx        = PW'(cfg.x_offset) + $signed(PW'(col_q));
		sy        = PW'(cfg.y_offset) + $signed(PW'(row_q));
		visible   = !sx[PW-1] && !sy[PW-1] &&
		            ($unsigned(sx) < clipw) && ($unsigned(sy) < cliph);
	end

	assign q_wr              = push && !q_full;
	assign q_data.coverage   = item.coverage;
	assign q_data.dest_pixel = item.dest_pixel;
	assign q_data.visible    = visible;
	assign q_data.col        = sx[12:0];
	assign q_data.row        = sy[12:0];
	assign q_data.done       = last_col && last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_wr) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : CW'(row_q + 1'b1);
			end else begin
				col_q <= CW'(col_q + 1'b1);
			end
		end
	end

endmodule

// ===== hw/rtl/gcb_back.sv =====
// blend and index datapath: products in one stage, divide and sum into the result queue
module gcb_back #(
	parameter int OUT_DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gcb_pkg::cfg_t              cfg,
	input  logic                       q_empty,
	input  gcb_pkg::task_t             q_data,
	output logic                       q_rd,
	input  logic [$clog2(OUT_DEPTH):0] out_count,
	output logic                       out_wr,
	output gcb_pkg::out_item_t         out_data
);

	localparam int CNTW = $clog2(OUT_DEPTH) + 2;

	logic [15:0] p_fg_s1  [4];
	logic [15:0] p_dst_s1 [4];
	logic [25:0] idx_prod_s1;
	logic [12:0] col_s1;
	logic [31:0] dst_s1;
	logic        inside_s1;
	logic        done_s1;
	logic        v_s1;
	logic [7:0]  inv_cov;
	logic [31:0] blend;
	logic [25:0] idx_sum;
	logic [8:0]  ch_sum [4];

	// reserve a result slot for the word already in the stage
	assign q_rd    = !q_empty &&
	                 ((CNTW'(out_count) + CNTW'(v_s1)) < CNTW'(OUT_DEPTH));
	assign inv_cov = 8'd255 - q_data.coverage;

	always_ff @(posedge clk) begin
		if (q_rd) begin
			for (int c = 0; c < 4; c++) begin
				p_fg_s1[c]  <= 16'(cfg.fg_color[8*c +: 8]) * 16'(q_data.coverage);
				p_dst_s1[c] <= 16'(q_data.dest_pixel[8*c +: 8]) * 16'(inv_cov);
			end
			idx_prod_s1 <= 26'(q_data.row) * 26'(cfg.line_size);
			col_s1      <= q_data.col;
			dst_s1      <= q_data.dest_pixel;
			inside_s1   <= q_data.visible;
			done_s1     <= q_data.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= q_rd;
		end
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			ch_sum[c]       = {1'b0, gcb_pkg::div255(p_fg_s1[c])} +
			                  {1'b0, gcb_pkg::div255(p_dst_s1[c])};
			blend[8*c +: 8] = ch_sum[c][7:0];
		end
		idx_sum = idx_prod_s1 + 26'(col_s1);
	end

	assign out_wr                 = v_s1;
	assign out_data.write_enable  = inside_s1;
	assign out_data.pixel_index   = inside_s1 ? idx_sum[23:0] : '0;
	assign out_data.blended_pixel = inside_s1 ? blend : dst_s1;
	assign out_data.glyph_done    = done_s1;

endmodule

// ===== hw/rtl/glyph_coverage_blend_top.sv =====
// glyph coverage blender top level: config registers, front, queues and back
//
//  channel   direction  handshake            payload
//  item      in         push / full          in_item_t (coverage, dest_pixel)
//  result    out        empty / pop          out_item_t (write_enable .. glyph_done)
//  config    in         cfg_we               cfg_index, cfg_data
//
// one pixel per clock sustained while results are popped; a taken pixel goes from the
// front into the classify queue, through one multiply stage, into the result queue
// reset clears the raster counters and both queues and loads the register defaults
// full rises when the four-entry classify queue fills; the back holds off once the
// four-entry result queue plus the word in its multiply stage would overflow
module glyph_coverage_blend_top #(
	parameter int MAX_GLYPH_SIZE   = 256,
	parameter int MAX_SURFACE_SIZE = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  gcb_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output gcb_pkg::out_item_t result,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int MAW = $clog2(gcb_pkg::MID_DEPTH);
	localparam int OAW = $clog2(gcb_pkg::OUT_DEPTH);

	gcb_pkg::cfg_t      cfg_q;
	gcb_pkg::task_t     front_task;
	gcb_pkg::task_t     mid_head;
	gcb_pkg::out_item_t back_word;
	logic               mid_wr;
	logic               mid_full;
	logic               mid_rd;
	logic               mid_empty;
	logic [MAW:0]       mid_count;
	logic               out_wr;
	logic               out_full;
	logic [OAW:0]       out_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fg_color    <= 32'hffff_ffff;
			cfg_q.x_offset    <= '0;
			cfg_q.y_offset    <= '0;
			cfg_q.glyph_cols  <= 9'd1;
			cfg_q.glyph_rows  <= 9'd1;
			cfg_q.clip_width  <= 13'd480;
			cfg_q.clip_height <= 13'd272;
			cfg_q.line_size   <= 13'd512;
		end else if (cfg_we) begin
			unique case (gcb_pkg::cfg_reg_e'(cfg_index))
				gcb_pkg::REG_FG_COLOR:    cfg_q.fg_color    <= cfg_data;
				gcb_pkg::REG_X_OFFSET:    cfg_q.x_offset    <= $signed(cfg_data[12:0]);
				gcb_pkg::REG_Y_OFFSET:    cfg_q.y_offset    <= $signed(cfg_data[12:0]);
				gcb_pkg::REG_GLYPH_COLS:  cfg_q.glyph_cols  <= cfg_data[8:0];
				gcb_pkg::REG_GLYPH_ROWS:  cfg_q.glyph_rows  <= cfg_data[8:0];
				gcb_pkg::REG_CLIP_WIDTH:  cfg_q.clip_width  <= cfg_data[12:0];
				gcb_pkg::REG_CLIP_HEIGHT: cfg_q.clip_height <= cfg_data[12:0];
				gcb_pkg::REG_LINE_SIZE:   cfg_q.line_size   <= cfg_data[12:0];
			endcase
		end
	end

	assign full = mid_full;

	gcb_front #(
		.MAX_GLYPH_SIZE   (MAX_GLYPH_SIZE),
		.MAX_SURFACE_SIZE (MAX_SURFACE_SIZE)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.push   (push),
		.item   (item),
		.q_full (mid_full),
		.q_wr   (mid_wr),
		.q_data (front_task)
	);

	gcb_fifo #(
		.W     ($bits(gcb_pkg::task_t)),
		.DEPTH (gcb_pkg::MID_DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_wr),
		.wr_data (front_task),
		.full    (mid_full),
		.rd_en   (mid_rd),
		.rd_data (mid_head),
		.empty   (mid_empty),
		.count   (mid_count)
	);

	gcb_back #(
		.OUT_DEPTH (gcb_pkg::OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (mid_empty),
		.q_data    (mid_head),
		.q_rd      (mid_rd),
		.out_count (out_count),
		.out_wr    (out_wr),
		.out_data  (back_word)
	);

	gcb_fifo #(
		.W     ($bits(gcb_pkg::out_item_t)),
		.DEPTH (gcb_pkg::OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_wr),
		.wr_data (back_word),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty),
		.count   (out_count)
	);

	// the back's slot reservation must keep the result queue from overflowing
	a_no_out_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_wr |-> !out_full)
		else $error("result word dropped on full queue");

	a_mid_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mid_count <= (MAW+1)'(gcb_pkg::MID_DEPTH))
		else $error("classify queue count out of range");

	a_taken_word_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> (mid_count != '0))
		else $error("accepted word missing from classify queue");

	a_skip_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.write_enable) |-> (result.pixel_index == '0))
		else $error("skipped pixel carries an index");

endmodule

// ===== sim/tb_glyph_coverage_blend_top.sv =====
// testbench for the glyph coverage blender: directed and random pixel streams checked against a predictor
`timescale 1ns / 100ps

module tb_glyph_coverage_blend_top;
	import gcb_pkg::*;

	localparam int GLYPH_MAX   = 256;
	localparam int SURFACE_MAX = 4096;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_PIXELS = 1700;
	localparam int HOLD_CYCLES = 300;

	class blend_scoreboard;
		logic [31:0] fg;
		int x_off, y_off;
		int unsigned g_cols, g_rows, clip_w, clip_h, stride;
		int unsigned col_pos, row_pos;
		out_item_t expected_pixels[$];
		int errors, pixels, written, glyph_ends, settings;

		function new();
			fg = 32'hFFFF_FFFF;
			x_off = 0;
			y_off = 0;
			g_cols = 1;
			g_rows = 1;
			clip_w = 480;
			clip_h = 272;
			stride = 512;
			col_pos = 0;
			row_pos = 0;
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 50)
				$display("[%0t] error: %s", $realtime, msg);
		endfunction

		function void set_reg(cfg_reg_e r, logic [31:0] d);
			case (r)
				REG_FG_COLOR:    fg = d;
				REG_X_OFFSET:    x_off = int'($signed(d[12:0]));
				REG_Y_OFFSET:    y_off = int'($signed(d[12:0]));
				REG_GLYPH_COLS:  g_cols = d[8:0];
				REG_GLYPH_ROWS:  g_rows = d[8:0];
				REG_CLIP_WIDTH:  clip_w = d[12:0];
				REG_CLIP_HEIGHT: clip_h = d[12:0];
				REG_LINE_SIZE:   stride = d[12:0];
				default: ;
			endcase
		endfunction

		function int unsigned glyph_dim(int unsigned v);
			if (v == 0)
				return 1;
			return (v > GLYPH_MAX) ? GLYPH_MAX : v;
		endfunction

		function int glyph_area();
			return glyph_dim(g_cols) * glyph_dim(g_rows);
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		// works out the word the block owes for one accepted pixel
		function void note_pixel(in_item_t px);
			int sx, sy, cw, ch;
			int unsigned cov, f, d, c;
			bit last_c, last_r, vis;
			out_item_t e;
			sx = x_off + int'(col_pos);
			sy = y_off + int'(row_pos);
			cw = (clip_w > SURFACE_MAX) ? SURFACE_MAX : clip_w;
			ch = (clip_h > SURFACE_MAX) ? SURFACE_MAX : clip_h;
			last_c = col_pos + 1 >= glyph_dim(g_cols);
			last_r = row_pos + 1 >= glyph_dim(g_rows);
			vis = sx >= 0 && sy >= 0 && sx < cw && sy < ch;
			cov = px.coverage;
			e.write_enable = vis;
			e.pixel_index = '0;
			e.blended_pixel = px.dest_pixel;
			e.glyph_done = last_c && last_r;
			if (vis) begin
				e.pixel_index = 24'((sy * int'(stride) + sx) & 32'h00FF_FFFF);
				for (int sh = 0; sh < 32; sh += 8) begin
					f = (fg >> sh) & 8'hFF;
					d = (px.dest_pixel >> sh) & 8'hFF;
					c = f * cov / 255 + (255 - cov) * d / 255;
					e.blended_pixel[sh +: 8] = c[7:0];
				end
				written++;
			end
			if (e.glyph_done)
				glyph_ends++;
			pixels++;
			expected_pixels.push_back(e);
			if (last_c) begin
				col_pos = 0;
				row_pos = last_r ? 0 : row_pos + 1;
			end else begin
				col_pos = col_pos + 1;
			end
		endfunction

		function void check_pixel(out_item_t got);
			out_item_t e;
			if (expected_pixels.size() == 0) begin
				report($sformatf("unexpected word %h", got));
				return;
			end
			e = expected_pixels.pop_front();
			if (got.write_enable !== e.write_enable)
				report($sformatf("write_enable %b, want %b", got.write_enable,
					e.write_enable));
			if (got.pixel_index !== e.pixel_index)
				report($sformatf("pixel_index %h, want %h", got.pixel_index,
					e.pixel_index));
			if (got.blended_pixel !== e.blended_pixel)
				report($sformatf("blended_pixel %h, want %h", got.blended_pixel,
					e.blended_pixel));
			if (got.glyph_done !== e.glyph_done)
				report($sformatf("glyph_done %b, want %b", got.glyph_done,
					e.glyph_done));
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	in_item_t   item;
	logic       empty;
	logic       pop;
	out_item_t  result;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	blend_scoreboard sb = new();
	int push_level;
	int pop_level;
	bit long_hold;
	int full_cycles;
	int cycle_count;
	int sent;

	glyph_coverage_blend_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				sb.note_pixel(item);
			if (pop && !empty)
				sb.check_pixel(result);
			if (push && full)
				full_cycles++;
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int idle_draw(int level);
		case (level)
			0: return 0;
			1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
			default: return $urandom_range(0, 19);
		endcase
	endfunction

	function automatic logic [7:0] rand_cov();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [8:0] rand_glyph_dim(int hi);
		if ($urandom_range(0, 9) == 0)
			return 9'($urandom_range(0, 511));
		return 9'($urandom_range(1, hi));
	endfunction

	function automatic logic [12:0] rand_clip();
		case ($urandom_range(0, 15))
			0: return 13'd0;
			1, 2: return 13'($urandom);
			3: return 13'(SURFACE_MAX);
			default: return 13'($urandom_range(1, 40));
		endcase
	endfunction

	function automatic logic [12:0] rand_offset();
		int v;
		if ($urandom_range(0, 7) == 0)
			return 13'($urandom);
		v = $urandom_range(0, 12) - 4;
		return v[12:0];
	endfunction

	function automatic cfg_t rand_config();
		cfg_t c;
		case ($urandom_range(0, 7))
			0: c.fg_color = 32'h0000_0000;
			1: c.fg_color = 32'hFFFF_FFFF;
			default: c.fg_color = $urandom;
		endcase
		c.x_offset = rand_offset();
		c.y_offset = rand_offset();
		c.glyph_cols = rand_glyph_dim(12);
		c.glyph_rows = rand_glyph_dim(8);
		c.clip_width = rand_clip();
		c.clip_height = rand_clip();
		c.line_size = ($urandom_range(0, 3) == 0) ? c.clip_width : 13'($urandom);
		return c;
	endfunction

	// receiver: random pauses per word, plus one long hold-off on request
	initial begin
		int gap;
		int held;
		pop <= 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (long_hold) begin
				pop <= 1'b0;
				held = 0;
				while (held < HOLD_CYCLES) begin
					@(negedge clk);
					held++;
				end
				long_hold = 1'b0;
			end else begin
				gap = idle_draw(pop_level);
				if (gap > 0) begin
					pop <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			@(negedge clk);
		end
	end

	// entered and left at a falling edge; push stays high when the next word follows at once
	task automatic send_pixel(logic [7:0] cov, logic [31:0] dest);
		int gap;
		gap = idle_draw(push_level);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		item <= '{coverage: cov, dest_pixel: dest};
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic write_reg(cfg_reg_e r, logic [31:0] d);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		sb.set_reg(r, d);
		@(negedge clk);
	endtask

	task automatic load_config(cfg_t c);
		write_reg(REG_FG_COLOR, c.fg_color);
		write_reg(REG_X_OFFSET, {{19{c.x_offset[12]}}, c.x_offset});
		write_reg(REG_Y_OFFSET, {{19{c.y_offset[12]}}, c.y_offset});
		write_reg(REG_GLYPH_COLS, {23'd0, c.glyph_cols});
		write_reg(REG_GLYPH_ROWS, {23'd0, c.glyph_rows});
		write_reg(REG_CLIP_WIDTH, {19'd0, c.clip_width});
		write_reg(REG_CLIP_HEIGHT, {19'd0, c.clip_height});
		write_reg(REG_LINE_SIZE, {19'd0, c.line_size});
		cfg_we <= 1'b0;
		sb.settings++;
	endtask

	// drop push, wait for every owed word, then let the pipeline go quiet
	task automatic settle();
		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic send_burst(int n);
		for (int i = 0; i < n; i++)
			send_pixel(rand_cov(), $urandom);
		settle();
	endtask

	initial begin
		int n;
		bit first;
		cfg_t c;
		arst_n <= 1'b0;
		push <= 1'b0;
		item <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_FG_COLOR;
		cfg_data <= '0;
		push_level = 0;
		pop_level = 1;
		long_hold = 1'b0;
		full_cycles = 0;
		sent = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// defaults: one-pixel glyph at the origin, coverage and pixel extremes
		send_pixel(8'd0, 32'h0000_0000);
		send_pixel(8'd255, 32'h0000_0000);
		send_pixel(8'd255, 32'hFFFF_FFFF);
		send_pixel(8'd0, 32'hFFFF_FFFF);
		settle();

		// negative start, tight clip, zero stride
		load_config('{fg_color: 32'h80FF_007F, x_offset: -13'sd1, y_offset: -13'sd1,
			glyph_cols: 9'd3, glyph_rows: 9'd3, clip_width: 13'd2, clip_height: 13'd2,
			line_size: 13'd0});
		send_burst(9);

		// zero glyph size, oversize clip, index wraps past 24 bits
		load_config('{fg_color: 32'hFFFF_FFFF, x_offset: 13'sd4095, y_offset: 13'sd4095,
			glyph_cols: 9'd0, glyph_rows: 9'd0, clip_width: 13'h1FFF,
			clip_height: 13'h1FFF, line_size: 13'h1FFF});
		send_burst(2);

		// oversize glyph width, zero clip width: nothing visible, row left half done
		load_config('{fg_color: 32'h0000_0000, x_offset: 13'sd0, y_offset: 13'sd0,
			glyph_cols: 9'h1FF, glyph_rows: 9'd2, clip_width: 13'd0,
			clip_height: 13'd4096, line_size: 13'd4096});
		send_burst(4);

		// narrower glyph while the column counter is past its end
		load_config('{fg_color: 32'h0000_0000, x_offset: 13'sd0, y_offset: 13'sd0,
			glyph_cols: 9'd2, glyph_rows: 9'd2, clip_width: 13'd4096,
			clip_height: 13'd4096, line_size: 13'd4096});
		send_burst(4);

		first = 1'b1;
		while (sent < RANDOM_PIXELS + 23) begin
			c = rand_config();
			load_config(c);
			push_level = $urandom_range(0, 2);
			pop_level = $urandom_range(0, 2);
			n = sb.glyph_area() * $urandom_range(1, 3);
			if (n > 150 || $urandom_range(0, 4) == 0)
				n = $urandom_range(5, 150);
			if (first) begin
				// receiver stops while the sender keeps pushing, so the input backs up
				push_level = 0;
				long_hold = 1'b1;
				n = 100;
				first = 1'b0;
			end
			send_burst(n);
		end

		settle();
		if (sb.pending() != 0)
			sb.report($sformatf("%0d words never arrived", sb.pending()));
		$display("covered %0d pixels over %0d register settings: %0d written, %0d glyph ends",
			sb.pixels, sb.settings, sb.written, sb.glyph_ends);
		$display("input held off by full for %0d cycles, %0d errors", full_cycles,
			sb.errors);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
